// ===== design/rit_pkg.sv =====
// Package: shared constants, register index codes and controller/datapath interface types.
package rit_pkg;

  localparam int DEFAULT_COUNT_WIDTH  = 24;
  localparam int DEFAULT_SAMPLE_WIDTH = 16;

  localparam int THR_WIDTH       = 16;
  localparam int DUTY_WIDTH      = 17;
  localparam int TRIG_WIDTH      = 24;
  localparam int LEVEL_WIDTH     = 16;
  localparam int SEED_WIDTH      = 32;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 32;

  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;

  localparam logic [DUTY_WIDTH-1:0]  DUTY_ONE       = 17'h10000;
  localparam logic [THR_WIDTH-1:0]   THR_RESET      = 16'h0000;
  localparam logic [DUTY_WIDTH-1:0]  DUTY_RESET     = 17'h08000;
  localparam logic [TRIG_WIDTH-1:0]  TRIG_RESET     = 24'd1;
  localparam logic [LEVEL_WIDTH-1:0] LEVEL_RESET    = 16'h7fff;
  localparam logic [SEED_WIDTH-1:0]  SEED_RESET     = 32'd0;
  localparam logic [31:0]            RNG_RESET      = 32'd1;
  localparam logic [31:0]            ROUND_HALF32   = 32'h8000_0000;
  localparam logic [15:0]            ROUND_HALF16   = 16'h8000;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_DUTY      = 3'd1,
    CFG_TRIG_LEN  = 3'd2,
    CFG_LEVEL     = 3'd3,
    CFG_SEED      = 3'd4
  } cfg_index_e;

  typedef struct packed {
    logic accept;
    logic prep;
    logic redraw;
    logic map;
    logic apply;
    logic gate;
    logic finish;
  } rit_cmd_t;

  typedef struct packed {
    logic map_needed;
    logic redraw_needed;
  } rit_sts_t;

  function automatic logic [31:0] rng_advance(input logic [31:0] s);
    logic [31:0] s_eff;
    s_eff = (s == 32'd0) ? 32'd1 : s;
    return 32'(LCG_MUL * s_eff + LCG_ADD);
  endfunction

endpackage

// ===== design/random_interval_trigger_clock.sv =====
// Top level: random-interval trigger and gate generator driven by sample ticks.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-------------------------------------------
//   input   | in_valid_i / in_stall_o    | reset_level_i, min_interval_i, max_interval_i
//   output  | out_valid_o / out_stall_i  | trigger_out_o, gate_out_o
//   config  | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Items are taken one at a time: a new item waits until the last one has finished. A draw
// or remap adds the map and apply steps, and a remap that reaches the phase forces a fresh
// draw and remap; the two multiplier steps (draw scaling, then gate length) run in series.
// Reset is asynchronous and active low; it restores configuration and generator state, not data.
// The output register holds a finished item while out_stall_i is high; the next item is
// accepted meanwhile and waits at its final step until the register frees.
// cfg_ready_o is always high; writes to unknown indexes are ignored.
module random_interval_trigger_clock
  import rit_pkg::*;
#(
  parameter int COUNT_WIDTH  = DEFAULT_COUNT_WIDTH,
  parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]    reset_level_i,
  input  logic        [COUNT_WIDTH-1:0]     min_interval_i,
  input  logic        [COUNT_WIDTH-1:0]     max_interval_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]    trigger_out_o,
  output logic signed [SAMPLE_WIDTH-1:0]    gate_out_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic        [CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  logic        [CFG_DATA_WIDTH-1:0]  cfg_data_i
);

  rit_cmd_t cmd;
  rit_sts_t sts;

  assign cfg_ready_o = 1'b1;

  rit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rit_dpath #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .reset_level_i  (reset_level_i),
    .min_interval_i (min_interval_i),
    .max_interval_i (max_interval_i),
    .trigger_out_o  (trigger_out_o),
    .gate_out_o     (gate_out_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

// ===== design/rit_ctrl.sv =====
// Controller: sequences the per-item steps and owns the output valid flag.
module rit_ctrl
  import rit_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  rit_sts_t sts_i,
  output rit_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PREP   = 7'b0000010,
    S_REDRAW = 7'b0000100,
    S_MAP    = 7'b0001000,
    S_ADD    = 7'b0010000,
    S_GATE   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = sts_i.map_needed ? S_MAP : S_GATE;
      end
      S_REDRAW: begin
        cmd_o.redraw = 1'b1;
        state_d      = S_MAP;
      end
      S_MAP: begin
        cmd_o.map = 1'b1;
        state_d   = S_ADD;
      end
      S_ADD: begin
        cmd_o.apply = 1'b1;
        state_d     = sts_i.redraw_needed ? S_REDRAW : S_GATE;
      end
      S_GATE: begin
        cmd_o.gate = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/rit_dpath.sv =====
// Datapath: configuration registers, generator, interval mapping, counters and output register.
module rit_dpath
  import rit_pkg::*;
#(
  parameter int COUNT_WIDTH  = DEFAULT_COUNT_WIDTH,
  parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic        [CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  logic        [CFG_DATA_WIDTH-1:0]  cfg_data_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    reset_level_i,
  input  logic        [COUNT_WIDTH-1:0]     min_interval_i,
  input  logic        [COUNT_WIDTH-1:0]     max_interval_i,
  output logic signed [SAMPLE_WIDTH-1:0]    trigger_out_o,
  output logic signed [SAMPLE_WIDTH-1:0]    gate_out_o,
  input  rit_cmd_t                          cmd_i,
  output rit_sts_t                          sts_o
);

  localparam int CW    = COUNT_WIDTH;
  localparam int PW    = COUNT_WIDTH + 32;
  localparam int GW    = COUNT_WIDTH + DUTY_WIDTH;
  localparam int CMP_W = (SAMPLE_WIDTH > THR_WIDTH) ? SAMPLE_WIDTH : THR_WIDTH;

  logic signed [THR_WIDTH-1:0]   thr_q;
  logic        [DUTY_WIDTH-1:0]  duty_q;
  logic        [TRIG_WIDTH-1:0]  trig_len_q;
  logic signed [LEVEL_WIDTH-1:0] level_q;
  logic        [SEED_WIDTH-1:0]  seed_q;

  logic signed [SAMPLE_WIDTH-1:0] rst_lvl_q;
  logic        [CW-1:0]           a_q, b_q;

  logic        [31:0]             rng_q, last_draw_q, applied_seed_q;
  logic        [CW-1:0]           ilen_q, prev_min_q, prev_max_q;
  logic        [CW:0]             phase_q;
  logic        [TRIG_WIDTH-1:0]   trig_rem_q;
  logic signed [SAMPLE_WIDTH-1:0] prev_rst_q;
  logic                           is_draw_q;

  logic        [PW-1:0]           span_prod_q;
  logic        [GW-1:0]           gate_prod_q;
  logic signed [SAMPLE_WIDTH-1:0] trigger_out_q, gate_out_q;

  logic                           seed_chg, rise_det, changed, do_draw, do_remap;
  logic        [31:0]             rng_eff, seed_eff, rng_new;
  logic        [CW-1:0]           ilen_eff, lo, hi, diff, span, new_len;
  logic        [CW:0]             phase_eff, gate_len;
  logic        [PW-1:0]           span_rnd;
  logic        [GW-1:0]           gate_rnd;
  logic        [DUTY_WIDTH-1:0]   duty_sat;
  logic signed [CMP_W-1:0]        rst_x, prev_x, thr_x;
  logic signed [SAMPLE_WIDTH-1:0] level_x;
  logic        [TRIG_WIDTH-1:0]   trig_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= THR_RESET;
      duty_q     <= DUTY_RESET;
      trig_len_q <= TRIG_RESET;
      level_q    <= LEVEL_RESET;
      seed_q     <= SEED_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD: thr_q      <= cfg_data_i[THR_WIDTH-1:0];
        CFG_DUTY:      duty_q     <= cfg_data_i[DUTY_WIDTH-1:0];
        CFG_TRIG_LEN:  trig_len_q <= cfg_data_i[TRIG_WIDTH-1:0];
        CFG_LEVEL:     level_q    <= cfg_data_i[LEVEL_WIDTH-1:0];
        CFG_SEED:      seed_q     <= cfg_data_i[SEED_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign lo   = (a_q < b_q) ? a_q : b_q;
  assign hi   = (a_q < b_q) ? b_q : a_q;
  assign diff = hi - lo;

  assign seed_chg  = (seed_q != applied_seed_q);
  assign seed_eff  = (seed_q == '0) ? RNG_RESET : seed_q;
  assign rng_eff   = seed_chg ? seed_eff : rng_q;
  assign ilen_eff  = seed_chg ? '0 : ilen_q;
  assign phase_eff = seed_chg ? '0 : phase_q;

  assign rst_x    = CMP_W'(rst_lvl_q);
  assign prev_x   = CMP_W'(prev_rst_q);
  assign thr_x    = CMP_W'(thr_q);
  assign rise_det = (prev_x <= thr_x) && (rst_x > thr_x);
  assign changed  = (prev_min_q != a_q) || (prev_max_q != b_q);
  assign do_draw  = rise_det || (ilen_eff == '0) ||
                    (!changed && (phase_eff >= {1'b0, ilen_eff}));
  assign do_remap = !do_draw && changed;

  assign rng_new = rng_advance(cmd_i.prep ? rng_eff : rng_q);

  assign span_rnd = span_prod_q + PW'(ROUND_HALF32);
  assign span     = span_rnd[PW-1:32];
  assign new_len  = ((lo + span) == '0) ? CW'(1) : (lo + span);

  assign duty_sat = (duty_q > DUTY_ONE) ? DUTY_ONE : duty_q;
  assign gate_rnd = gate_prod_q + GW'(ROUND_HALF16);
  assign gate_len = gate_rnd[GW-1:16];

  assign level_x   = SAMPLE_WIDTH'(level_q);
  assign trig_load = (trig_len_q == '0) ? TRIG_WIDTH'(1) : trig_len_q;

  assign sts_o.map_needed    = do_draw || do_remap;
  assign sts_o.redraw_needed = !is_draw_q && (phase_q >= {1'b0, new_len});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rng_q          <= RNG_RESET;
      last_draw_q    <= '0;
      ilen_q         <= '0;
      phase_q        <= '0;
      trig_rem_q     <= '0;
      prev_rst_q     <= '0;
      prev_min_q     <= '0;
      prev_max_q     <= '0;
      applied_seed_q <= '0;
      is_draw_q      <= 1'b0;
    end else begin
      if (cmd_i.prep) begin
        prev_min_q <= a_q;
        prev_max_q <= b_q;
        if (seed_chg) begin
          applied_seed_q <= seed_q;
          ilen_q         <= '0;
          phase_q        <= '0;
          trig_rem_q     <= '0;
        end
        is_draw_q <= do_draw;
        if (do_draw) begin
          rng_q       <= rng_new;
          last_draw_q <= rng_new;
        end
      end
      if (cmd_i.redraw) begin
        rng_q       <= rng_new;
        last_draw_q <= rng_new;
        is_draw_q   <= 1'b1;
      end
      if (cmd_i.apply) begin
        ilen_q <= new_len;
        if (is_draw_q) begin
          phase_q    <= '0;
          trig_rem_q <= trig_load;
        end
      end
      if (cmd_i.finish) begin
        if (trig_rem_q != '0) begin
          trig_rem_q <= trig_rem_q - TRIG_WIDTH'(1);
        end
        if (phase_q != '1) begin
          phase_q <= phase_q + (CW + 1)'(1);
        end
        prev_rst_q <= rst_lvl_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rst_lvl_q <= reset_level_i;
      a_q       <= min_interval_i;
      b_q       <= max_interval_i;
    end
    if (cmd_i.map) begin
      span_prod_q <= PW'(diff) * PW'(last_draw_q);
    end
    if (cmd_i.gate) begin
      gate_prod_q <= GW'(ilen_q) * GW'(duty_sat);
    end
    if (cmd_i.finish) begin
      trigger_out_q <= (trig_rem_q != '0) ? level_x : '0;
      gate_out_q    <= (phase_q < gate_len) ? level_x : '0;
    end
  end

  assign trigger_out_o = trigger_out_q;
  assign gate_out_o    = gate_out_q;

endmodule

// ===== design/rit_checker.sv =====
// Checker: port-level properties of the trigger clock, bound to the top level.
module rit_checker
  import rit_pkg::*;
#(
  parameter int COUNT_WIDTH  = DEFAULT_COUNT_WIDTH,
  parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic signed [SAMPLE_WIDTH-1:0]    reset_level_i,
  input logic        [COUNT_WIDTH-1:0]     min_interval_i,
  input logic        [COUNT_WIDTH-1:0]     max_interval_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [SAMPLE_WIDTH-1:0]    trigger_out_o,
  input logic signed [SAMPLE_WIDTH-1:0]    gate_out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(trigger_out_o) &&
                                   $stable(gate_out_o))
    else $error("stalled output item changed");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(reset_level_i) &&
                                 $stable(min_interval_i) && $stable(max_interval_i))
    else $error("stalled input item changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after an accepted item");

  a_levels_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (trigger_out_o != '0) && (gate_out_o != '0) |->
      trigger_out_o == gate_out_o)
    else $error("trigger and gate show different active levels");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in work");

endmodule

bind random_interval_trigger_clock rit_checker #(
  .COUNT_WIDTH  (COUNT_WIDTH),
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_rit_checker (.*);
